// ===== src/idb_pkg.sv =====
// idb_pkg: shared types and constants for the integrating input debouncer.
// No dependencies; used by the top level and its checker.
package idb_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNELS_DEF   = 7;
    localparam int TIMER_BITS_DEF = 16;

    // Width of the delay and step registers
    localparam int REG_W = 16;

    // Register reset values
    localparam logic [REG_W-1:0] DELAY_LIMIT_RST = 16'd1000;
    localparam logic [REG_W-1:0] RISE_STEP_RST   = 16'd10;
    localparam logic [REG_W-1:0] FALL_STEP_RST   = 16'd10;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_LIMIT = 2'd0,
        CFG_RISE_STEP   = 2'd1,
        CFG_FALL_STEP   = 2'd2,
        CFG_INVERT_MASK = 2'd3
    } t_cfg_idx;

endpackage

// ===== src/integrating_input_debouncer.sv =====
// integrating_input_debouncer: top level, per-channel integrating debounce timers.
// Depends on idb_pkg (constants, register index enum).
//
//  channel   dir  fields (tdata / data, lowest bit up)        beat taken when
//  s_axis    in   raw_bits[CHANNELS-1:0], zero pad to byte     tvalid & tready
//  m_axis    out  qualified_bits[CHANNELS-1:0], zero pad       tvalid & tready
//  cfg       in   idx: register index, wdata: register value   i_cfg_we
//
// Cycles: one beat per clock sustained while m_axis is not stalled; each input beat goes
// through the input register, then the timer update and the result register.
// The per-channel add / compare / clamp between those two registers sets the rate.
// Reset (i_rst_n low, synchronous) clears timers, qualified state and both valids,
// and loads the register reset values.
// A stalled m_axis holds its beat; s_axis keeps accepting until both stages are full.
module integrating_input_debouncer #(
    parameter int CHANNELS   = idb_pkg::CHANNELS_DEF,
    parameter int TIMER_BITS = idb_pkg::TIMER_BITS_DEF,
    localparam int TDATA_W   = ((CHANNELS + 7) / 8) * 8,
    localparam int CFG_W     = (CHANNELS > idb_pkg::REG_W) ? CHANNELS : idb_pkg::REG_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [idb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]               i_cfg_wdata,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [TDATA_W-1:0]             i_s_axis_tdata,  // [CHANNELS-1:0] raw_bits
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [TDATA_W-1:0]             o_m_axis_tdata   // [CHANNELS-1:0] qualified_bits
);

    localparam int REG_W = idb_pkg::REG_W;
    // arithmetic width: room for timer + step without wrap
    localparam int CW = ((TIMER_BITS > REG_W) ? TIMER_BITS : REG_W) + 1;
    localparam logic [CW-1:0] TMAX_EXT = {{(CW-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};

    // ---------------- configuration registers ----------------
    logic [REG_W-1:0]    r_delay_limit;
    logic [REG_W-1:0]    r_rise_step;
    logic [REG_W-1:0]    r_fall_step;
    logic [CHANNELS-1:0] r_invert_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_limit <= idb_pkg::DELAY_LIMIT_RST;
            r_rise_step   <= idb_pkg::RISE_STEP_RST;
            r_fall_step   <= idb_pkg::FALL_STEP_RST;
            r_invert_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (idb_pkg::t_cfg_idx'(i_cfg_idx))
                idb_pkg::CFG_DELAY_LIMIT: r_delay_limit <= i_cfg_wdata[REG_W-1:0];
                idb_pkg::CFG_RISE_STEP:   r_rise_step   <= i_cfg_wdata[REG_W-1:0];
                idb_pkg::CFG_FALL_STEP:   r_fall_step   <= i_cfg_wdata[REG_W-1:0];
                idb_pkg::CFG_INVERT_MASK: r_invert_mask <= i_cfg_wdata[CHANNELS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic                r_in_valid;
    logic [CHANNELS-1:0] r_in_bits;
    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_bits;
    logic                w_advance;   // input stage moves into the timers / result reg

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_bits <= i_s_axis_tdata[CHANNELS-1:0];
        end
    end

    // ---------------- per-channel timer update ----------------
    logic [TIMER_BITS-1:0] r_timer [CHANNELS];
    logic [TIMER_BITS-1:0] n_timer [CHANNELS];
    logic [CHANNELS-1:0]   r_qual;
    logic [CHANNELS-1:0]   n_qual;
    logic [CHANNELS-1:0]   w_active;

    assign w_active = r_in_bits ^ r_invert_mask;

    always_comb begin
        logic [CW-1:0] t_ext;
        logic [CW-1:0] lim_ext;
        logic [CW-1:0] rise_ext;
        logic [CW-1:0] fall_ext;
        logic [CW-1:0] sum;
        lim_ext  = CW'(r_delay_limit);
        rise_ext = CW'(r_rise_step);
        fall_ext = CW'(r_fall_step);
        n_qual   = r_qual;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            t_ext = CW'(r_timer[ch]);
            sum   = t_ext + rise_ext;
            n_timer[ch] = r_timer[ch];
            if (w_active[ch]) begin
                if (t_ext < lim_ext) begin
                    // climb, saturating at the timer's top
                    n_timer[ch] = (sum > TMAX_EXT) ? {TIMER_BITS{1'b1}}
                                                   : sum[TIMER_BITS-1:0];
                end else begin
                    // at or past the limit: turn on, clamp (limit <= timer here)
                    n_qual[ch]  = 1'b1;
                    n_timer[ch] = lim_ext[TIMER_BITS-1:0];
                end
            end else begin
                if (t_ext != '0) begin
                    n_timer[ch] = (t_ext > fall_ext) ? TIMER_BITS'(t_ext - fall_ext)
                                                     : '0;
                end else begin
                    n_qual[ch] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qual <= '0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_timer[ch] <= '0;
            end
        end else if (w_advance) begin
            r_qual <= n_qual;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_timer[ch] <= n_timer[ch];
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_bits <= n_qual;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_bits);

endmodule

// ===== src/idb_checker.sv =====
// idb_checker: port-level checks for integrating_input_debouncer, bound to the top.
// Depends on idb_pkg for the default channel count.
module idb_checker #(
    parameter int CHANNELS = idb_pkg::CHANNELS_DEF,
    localparam int TDATA_W = ((CHANNELS + 7) / 8) * 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tready,
    input logic               i_m_tvalid,
    input logic               i_m_tready,
    input logic [TDATA_W-1:0] i_m_tdata
);

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> i_s_tready && !i_m_tvalid)
        else $error("pipeline not empty after reset");

    // input side only stalls when a result is held back downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_s_tready |-> i_m_tvalid && !i_m_tready)
        else $error("input stalled without downstream backpressure");

    // held result beat keeps its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result beat changed while stalled");

    // pad bits above the channels stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata >> CHANNELS) == '0)
        else $error("nonzero pad bits in result");

endmodule

bind integrating_input_debouncer idb_checker #(.CHANNELS(CHANNELS)) u_idb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
